/* hw/rtl/okvm_pkg.sv */
// ----------------------------------------------------------------------------
// okvm_pkg
// Shared types and constants for the insertion-ordered key/value multimap.
// ----------------------------------------------------------------------------
package okvm_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 64;
  localparam int ENT_W   = KEY_W + VAL_W;
  localparam int TALLY_W = 6;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  // status codes of a result item
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_WALK
  } state_t;

  // one result item
  typedef struct packed {
    status_t             status;
    logic                hit;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    value;
    logic [TALLY_W-1:0]  tally;
    logic                last;
  } res_t;

endpackage

/* hw/rtl/okvm_ram.sv */
// ----------------------------------------------------------------------------
// okvm_ram
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module okvm_ram
  import okvm_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [ENT_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [ENT_W-1:0] rdata
);

  logic [ENT_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/okvm_obuf.sv */
// ----------------------------------------------------------------------------
// okvm_obuf
// Output register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module okvm_obuf
  import okvm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res,
  input  logic ready,
  output logic valid,
  output res_t q,
  output logic free
);

  // slot can take a new item when empty or being drained
  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= res;
    end
  end

endmodule

/* hw/rtl/ordered_key_value_multimap.sv */
// ----------------------------------------------------------------------------
// ordered_key_value_multimap
// Insertion-ordered table of (key, value) pairs with repeated keys allowed.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | op, key, value
//  out     | out_valid / out_ready| status, hit, out_key, out_value, tally, last
//
//  one item at a time: in_ready is high only while the sequencer is idle
//  add: S_ADD loads the result once the output slot is free, then returns to idle
//  remove, find, dump: one memory read per stored entry, through the single read
//  port of the entry memory, then the closing result (the only one on an empty
//  table) and a return to idle; a full output slot stalls both add and walk
//  reset clears the entry count and control state, the entry memory needs no clearing
// ----------------------------------------------------------------------------
module ordered_key_value_multimap
  import okvm_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               op,
  input  logic signed [KEY_W-1:0]  key,
  input  logic [VAL_W-1:0]         value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic                     hit,
  output logic signed [KEY_W-1:0]  out_key,
  output logic [VAL_W-1:0]         out_value,
  output logic [TALLY_W-1:0]       tally,
  output logic                     last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     ridx, ridx_next;
  logic [CW-1:0]     widx, widx_next;
  logic              rd_valid, rd_valid_next;
  logic              pend_v, pend_v_next;
  logic [ENT_W-1:0]  pend, pend_next;
  op_t               cur_op;
  logic [KEY_W-1:0]  cur_key;
  logic [VAL_W-1:0]  cur_val;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;
  logic [KEY_W-1:0]  rkey;

  logic              ob_load, ob_free;
  res_t              ob_res, ob_q;

  logic              accept, is_match, consume, issue;

  assign accept = in_valid && in_ready;
  assign rkey   = ram_rdata[ENT_W-1 -: KEY_W];

  okvm_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ridx[AW-1:0]),
    .rdata (ram_rdata)
  );

  okvm_obuf u_obuf (
    .clk   (clk),
    .rst   (rst),
    .load  (ob_load),
    .res   (ob_res),
    .ready (out_ready),
    .valid (out_valid),
    .q     (ob_q),
    .free  (ob_free)
  );

  assign status    = ob_q.status;
  assign hit       = ob_q.hit;
  assign out_key   = ob_q.key;
  assign out_value = ob_q.value;
  assign tally     = ob_q.tally;
  assign last      = ob_q.last;

  // walk step conditions
  assign is_match = (cur_op == OP_DUMP) || ((cur_op == OP_FIND) && (rkey == cur_key));
  assign consume  = rd_valid && (!(is_match && pend_v) || ob_free);
  assign issue    = (state == S_WALK) && (ridx < count) && (!rd_valid || consume);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
      pend_v   <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rd_valid <= rd_valid_next;
      pend_v   <= pend_v_next;
    end
  end

  // indexes, held match and latched item
  always_ff @(posedge clk) begin
    ridx <= ridx_next;
    widx <= widx_next;
    pend <= pend_next;
    if (accept) begin
      cur_op  <= op_t'(op);
      cur_key <= key;
      cur_val <= value;
    end
  end

  // sequencer
  always_comb begin
    state_next    = state;
    count_next    = count;
    ridx_next     = ridx;
    widx_next     = widx;
    rd_valid_next = rd_valid;
    pend_v_next   = pend_v;
    pend_next     = pend;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = count[AW-1:0];
    ram_wdata     = {cur_key, cur_val};
    ram_re        = 1'b0;
    ob_load       = 1'b0;
    ob_res        = '0;
    ob_res.status = ST_OK;
    ob_res.last   = 1'b1;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ridx_next     = '0;
          widx_next     = '0;
          rd_valid_next = 1'b0;
          pend_v_next   = 1'b0;
          state_next    = (op_t'(op) == OP_ADD) ? S_ADD : S_WALK;
        end
      end

      S_ADD: begin
        if (ob_free) begin
          ob_load = 1'b1;
          if (count >= FULL_CNT) begin
            ob_res.status = ST_FULL;
            ob_res.tally  = TALLY_W'(count);
          end else begin
            ram_we       = 1'b1;
            count_next   = count + 1'b1;
            ob_res.tally = TALLY_W'(count + 1'b1);
          end
          state_next = S_IDLE;
        end
      end

      S_WALK: begin
        // entry fetched by the last read, held in the read register until consumed
        if (rd_valid && consume) begin
          if (cur_op == OP_REMOVE) begin
            if (rkey != cur_key) begin
              ram_we    = 1'b1;
              ram_waddr = widx[AW-1:0];
              ram_wdata = ram_rdata;
              widx_next = widx + 1'b1;
            end
          end else if (is_match) begin
            if (pend_v) begin
              ob_load      = 1'b1;
              ob_res.hit   = 1'b1;
              ob_res.key   = pend[ENT_W-1 -: KEY_W];
              ob_res.value = pend[VAL_W-1:0];
              ob_res.last  = 1'b0;
            end
            pend_v_next = 1'b1;
            pend_next   = ram_rdata;
          end
        end

        // next read
        if (issue) begin
          ram_re        = 1'b1;
          ridx_next     = ridx + 1'b1;
          rd_valid_next = 1'b1;
        end else if (consume) begin
          rd_valid_next = 1'b0;
        end

        // closing result once every entry has been seen
        if (!rd_valid && (ridx == count) && ob_free) begin
          ob_load = 1'b1;
          if (cur_op == OP_REMOVE) begin
            ob_res.tally = TALLY_W'(count - widx);
            count_next   = widx;
          end else if (pend_v) begin
            ob_res.hit   = 1'b1;
            ob_res.key   = pend[ENT_W-1 -: KEY_W];
            ob_res.value = pend[VAL_W-1:0];
          end else if (cur_op == OP_FIND) begin
            ob_res.status = ST_NONE;
          end
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // entry count never passes the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("entry count above capacity");

  // reads stay below the entry count
  a_read_range: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (ridx < count))
    else $error("read beyond entry count");

  // compaction writes never overtake the read pointer
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state == S_WALK)) |-> (widx < ridx))
    else $error("compaction write ahead of read");

  // no read in flight while idle
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rd_valid)
    else $error("read pending while idle");
`endif

endmodule

/* tb/sv/okvm_checker.sv */
// ----------------------------------------------------------------------------
// okvm_checker
// Watches both channels of the multimap table, keeps its own copy of the
// ordered table, predicts every result item and compares each one as it leaves.
// ----------------------------------------------------------------------------
module okvm_checker
  import okvm_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               op,
  input  logic signed [KEY_W-1:0]  key,
  input  logic [VAL_W-1:0]         value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [1:0]               status,
  input  logic                     hit,
  input  logic signed [KEY_W-1:0]  out_key,
  input  logic [VAL_W-1:0]         out_value,
  input  logic [TALLY_W-1:0]       tally,
  input  logic                     last,
  output int                       err_count,
  output int                       pending,
  output int                       n_items,
  output int                       n_results,
  output int                       n_full,
  output int                       n_miss,
  output int                       max_dump
);

  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the ordered table
  logic [KEY_W-1:0] key_tab [DEPTH];
  logic [VAL_W-1:0] val_tab [DEPTH];
  int               held;

  // results still owed by the block, oldest first
  res_t             owed_q [$];

  int               errs;
  int               items;
  int               results;
  int               fulls;
  int               misses;
  int               longest;

  task automatic report(string msg);
    errs++;
    $display("mismatch: %s", msg);
  endtask

  task automatic owe_result(status_t st, logic h, logic [KEY_W-1:0] k,
                            logic [VAL_W-1:0] v, int t, logic lst);
    res_t r;
    r.status = st;
    r.hit    = h;
    r.key    = k;
    r.value  = v;
    r.tally  = TALLY_W'(t);
    r.last   = lst;
    owed_q.insert(owed_q.size(), r);
  endtask

  // apply one input item to the shadow table and queue what it must produce
  task automatic apply_item(op_t o, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int i;
    int w;
    int hits;
    int seen;
    case (o)
      OP_ADD: begin
        if (held >= DEPTH) begin
          owe_result(ST_FULL, 1'b0, '0, '0, held, 1'b1);
          fulls++;
        end else begin
          key_tab[held] = k;
          val_tab[held] = v;
          held++;
          owe_result(ST_OK, 1'b0, '0, '0, held, 1'b1);
        end
      end
      OP_REMOVE: begin
        // compact the survivors in order
        w = 0;
        for (i = 0; i < held; i++) begin
          if (key_tab[i] != k) begin
            key_tab[w] = key_tab[i];
            val_tab[w] = val_tab[i];
            w++;
          end
        end
        owe_result(ST_OK, 1'b0, '0, '0, held - w, 1'b1);
        held = w;
      end
      OP_FIND: begin
        hits = 0;
        for (i = 0; i < held; i++)
          if (key_tab[i] == k) hits++;
        if (hits == 0) begin
          owe_result(ST_NONE, 1'b0, '0, '0, 0, 1'b1);
          misses++;
        end else begin
          seen = 0;
          for (i = 0; i < held; i++) begin
            if (key_tab[i] == k) begin
              seen++;
              owe_result(ST_OK, 1'b1, key_tab[i], val_tab[i], 0, seen == hits);
            end
          end
        end
      end
      default: begin
        // dump: every pair, or a lone end marker on an empty table
        if (held == 0) begin
          owe_result(ST_OK, 1'b0, '0, '0, 0, 1'b1);
        end else begin
          for (i = 0; i < held; i++)
            owe_result(ST_OK, 1'b1, key_tab[i], val_tab[i], 0, i == held - 1);
          if (held > longest) longest = held;
        end
      end
    endcase
  endtask

  // sample both channels at each edge
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      held = 0;
      owed_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        items++;
        apply_item(op_t'(op), key, value);
      end
      if (out_valid && out_ready) begin
        results++;
        if (owed_q.size() == 0) begin
          report($sformatf("result %0d arrived with nothing owed", results));
        end else begin
          want = owed_q.pop_front();
          if (status !== want.status)
            report($sformatf("result %0d status %0d, expected %0d",
                             results, status, want.status));
          if (hit !== want.hit)
            report($sformatf("result %0d hit %0b, expected %0b",
                             results, hit, want.hit));
          if (out_key !== want.key)
            report($sformatf("result %0d out_key %h, expected %h",
                             results, out_key, want.key));
          if (out_value !== want.value)
            report($sformatf("result %0d out_value %h, expected %h",
                             results, out_value, want.value));
          if (tally !== want.tally)
            report($sformatf("result %0d tally %0d, expected %0d",
                             results, tally, want.tally));
          if (last !== want.last)
            report($sformatf("result %0d last %0b, expected %0b",
                             results, last, want.last));
        end
      end
    end
    pending   <= owed_q.size();
    err_count <= errs;
    n_items   <= items;
    n_results <= results;
    n_full    <= fulls;
    n_miss    <= misses;
    max_dump  <= longest;
  end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the multimap table with directed corner items and then random
// sequences of adds, fills, finds, removes, dumps and noise, with random
// stalls on both channels; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb
  import okvm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 32;
  localparam int N_ITEMS   = 380;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG  = 4000;
  localparam int TAIL      = DEPTH + 10;
  localparam int POOL_N    = 6;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               op;
  logic signed [KEY_W-1:0]  key;
  logic [VAL_W-1:0]         value;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               status;
  logic                     hit;
  logic signed [KEY_W-1:0]  out_key;
  logic [VAL_W-1:0]         out_value;
  logic [TALLY_W-1:0]       tally;
  logic                     last;

  int err_count;
  int pending;
  int n_items;
  int n_results;
  int n_full;
  int n_miss;
  int max_dump;

  int          sent;
  int          idle_cycles;
  bit          steady;
  int          hold_asks;
  int          holds_done;
  logic [31:0] key_pool [POOL_N];

  ordered_key_value_multimap #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .key       (key),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .hit       (hit),
    .out_key   (out_key),
    .out_value (out_value),
    .tally     (tally),
    .last      (last)
  );

  okvm_checker #(.DEPTH(DEPTH)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .key       (key),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .hit       (hit),
    .out_key   (out_key),
    .out_value (out_value),
    .tally     (tally),
    .last      (last),
    .err_count (err_count),
    .pending   (pending),
    .n_items   (n_items),
    .n_results (n_results),
    .n_full    (n_full),
    .n_miss    (n_miss),
    .max_dump  (max_dump)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return key_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic refresh_pool();
    int i;
    for (i = 0; i < POOL_N; i++) key_pool[i] = $urandom();
    // keep one corner key in play
    case ($urandom_range(0, 3))
      0:       key_pool[0] = 32'h8000_0000;
      1:       key_pool[0] = 32'h7fff_ffff;
      2:       key_pool[0] = 32'h0000_0000;
      default: key_pool[0] = 32'hffff_ffff;
    endcase
  endtask

  // offer one item, hold it until taken, then maybe idle
  task automatic push_item(op_t o, logic [31:0] k, logic [63:0] v);
    int g;
    in_valid <= 1'b1;
    op       <= o;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    sent++;
    g = steady ? 0 : (($urandom_range(0, 3) == 0) ? gap_len() : 0);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // stop offering until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready  = 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_asks) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!steady && !rst && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("no handshake for %0d cycles", WATCHDOG);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int seq;
    int n;
    int j;
    logic [31:0] k;
    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = OP_ADD;
    key       = '0;
    value     = '0;
    steady    = 1'b0;
    hold_asks = 0;
    sent      = 0;
    refresh_pool();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table corners
    push_item(OP_DUMP,   32'h0000_0000, 64'h0);
    push_item(OP_FIND,   32'h0000_0001, 64'h0);
    push_item(OP_REMOVE, 32'h0000_0001, 64'h0);
    // extreme keys and values, one repeated key
    push_item(OP_ADD,    32'h8000_0000, 64'h0);
    push_item(OP_ADD,    32'h7fff_ffff, 64'hffff_ffff_ffff_ffff);
    push_item(OP_ADD,    32'h0000_0000, 64'h5555_5555_5555_5555);
    push_item(OP_ADD,    32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa);
    push_item(OP_ADD,    32'h7fff_ffff, 64'h1);
    push_item(OP_FIND,   32'h7fff_ffff, 64'h0);
    push_item(OP_FIND,   32'h0000_3039, 64'h0);
    push_item(OP_DUMP,   32'h0000_0000, 64'hffff_ffff_ffff_ffff);
    push_item(OP_REMOVE, 32'h7fff_ffff, 64'h0);
    push_item(OP_REMOVE, 32'h0000_3039, 64'h0);
    push_item(OP_DUMP,   32'h0000_0000, 64'h0);
    push_item(OP_REMOVE, 32'h0000_0000, 64'h0);
    push_item(OP_REMOVE, 32'h8000_0000, 64'h0);
    push_item(OP_REMOVE, 32'hffff_ffff, 64'h0);
    push_item(OP_DUMP,   32'h0000_0000, 64'h0);
    drain();

    // random sequences
    seq = 0;
    while (sent < N_ITEMS) begin
      seq++;
      steady = (seq % 6 == 0);
      if (seq == 8 || seq == 27) hold_asks++;
      if (seq % 9 == 0) drain();
      if (seq % 5 == 0) refresh_pool();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(1, 8);
          for (j = 0; j < n; j++) push_item(OP_ADD, pick_key(), pick_value());
        end
        3: begin
          // fill past capacity so adds get dropped
          n = DEPTH + $urandom_range(1, 3);
          for (j = 0; j < n; j++) push_item(OP_ADD, pick_key(), pick_value());
        end
        4, 5: begin
          n = $urandom_range(1, 3);
          for (j = 0; j < n; j++) push_item(OP_FIND, pick_key(), pick_value());
        end
        6: push_item(OP_REMOVE, pick_key(), pick_value());
        7: push_item(OP_DUMP, $urandom(), pick_value());
        8: begin
          // noise: any op, any key
          n = $urandom_range(1, 4);
          for (j = 0; j < n; j++)
            push_item(op_t'($urandom_range(0, 3)), $urandom(), pick_value());
        end
        default: begin
          // look up, delete, look up again
          k = pick_key();
          push_item(OP_FIND,   k, pick_value());
          push_item(OP_REMOVE, k, pick_value());
          push_item(OP_FIND,   k, pick_value());
        end
      endcase
    end
    steady = 1'b0;

    drain();
    repeat (TAIL) @(posedge clk);

    $display("run covered %0d items and %0d results in %0d random sequences",
             n_items, n_results, seq);
    $display("%0d adds dropped on a full table, %0d finds missed, longest dump %0d",
             n_full, n_miss, max_dump);
    if (err_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", err_count, pending);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
